// ----- sv/assert_macros.svh -----
// Assertion macros shared by the rasterizer RTL.
// Expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define FRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition that must never be true outside reset.
`define FRS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ----- sv/frs_pkg.sv -----
// Shared types and constants of the filled shape rasterizer.
// No dependencies; used by filled_shape_rasterizer, frs_checker and the testbench.
package frs_pkg;

  localparam int CANVAS_SIZE_DEF = 512;
  localparam int COORD_W         = 9;
  localparam int LEVEL_W         = 8;
  localparam int RAD_W           = 8;
  localparam int FUNC_W          = 2;

  localparam logic [LEVEL_W-1:0] WHITE_LEVEL = 8'd255;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_RECT   = 2'd0,
    FUNC_TRI    = 2'd1,
    FUNC_CIRCLE = 2'd2,
    FUNC_READ   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW,
    ST_SPAN,
    ST_READ
  } state_t;

endpackage

// ----- sv/frs_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
// No dependencies; used for the frame store.
module frs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/filled_shape_rasterizer.sv -----
// Filled shape rasterizer: top level with the draw sequencer and frame store.
// Depends on frs_pkg, frs_ram and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command per transfer:
//   rectangle, triangle, circle or pixel read. Draw commands give no result;
//   a read gives one transfer on the output channel (out_valid/out_ready).
//   Commands run one at a time. A draw holds in_ready low while it walks
//   its rows (stopping at the bottom edge) and their clipped spans, one
//   pixel per cycle through the single frame store port.
//   A read holds in_ready low in ST_READ, which loads the frame store data,
//   read at the transfer edge, into the output register and raises out_valid.
//   A finished read waits in the output register while further draws are
//   taken; a read is only taken once the output register is free or being
//   drained in the same cycle, so a stalled receiver holds back reads only.
//   Reset starts a clearing pass that writes white to every frame store
//   entry, one per cycle. in_ready stays low until the pass ends.
//   Reads of pixels outside the canvas return 0.
`include "assert_macros.svh"

module filled_shape_rasterizer
  import frs_pkg::*;
#(
  parameter int CANVAS_SIZE = CANVAS_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [COORD_W-1:0] in_x_pos,
  input  logic [COORD_W-1:0] in_y_pos,
  input  logic [COORD_W-1:0] in_box_width,
  input  logic [COORD_W-1:0] in_box_height,
  input  logic [RAD_W-1:0]   in_circle_radius,
  input  logic [LEVEL_W-1:0] in_gray_level,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LEVEL_W-1:0] out_pixel_value
);

  localparam int CW    = $clog2(CANVAS_SIZE);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int SW    = (CW + 2 > 12) ? CW + 2 : 12;
  localparam int DW    = RAD_W + 1;
  localparam int D2W   = 2 * RAD_W + 2;
  localparam int SQW   = 2 * RAD_W;

  localparam logic signed [SW-1:0] CANVAS_S = SW'(CANVAS_SIZE);
  localparam logic signed [SW-1:0] MAX_COL  = SW'(CANVAS_SIZE - 1);

  state_t                    state_r, state_nxt;
  func_t                     func_r, func_nxt;
  logic [AW-1:0]             clr_r, clr_nxt;
  logic [LEVEL_W-1:0]        level_r, level_nxt;
  logic signed [SW-1:0]      row_r, row_nxt;
  logic signed [SW-1:0]      col_r, col_nxt;
  logic signed [SW-1:0]      lo_r, lo_nxt;
  logic signed [SW-1:0]      hi_r, hi_nxt;
  logic signed [SW-1:0]      span_hi_r, span_hi_nxt;
  logic [COORD_W-1:0]        rows_left_r, rows_left_nxt;
  logic [RAD_W-1:0]          radius_r, radius_nxt;
  logic [SQW-1:0]            lim_r, lim_nxt;
  logic signed [DW-1:0]      dx_r, dx_nxt;
  logic signed [DW-1:0]      dy_r, dy_nxt;
  logic signed [D2W-1:0]     dx2_r, dx2_nxt;
  logic signed [D2W-1:0]     dy2_r, dy2_nxt;
  logic                      rd_in_r, rd_in_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0]        out_pixel_value_r, out_pixel_value_nxt;

  logic                      mem_en;
  logic                      mem_we;
  logic [AW-1:0]             mem_addr;
  logic [LEVEL_W-1:0]        mem_wdata;
  logic [LEVEL_W-1:0]        mem_rdata;

  logic                      in_xfer;
  logic signed [SW-1:0]      x_s, y_s, w_s, half_h_s, r_s;
  logic [SQW-1:0]            rad_sq;
  logic signed [SW-1:0]      c0, c1;
  logic signed [DW-1:0]      neg_rad;
  logic signed [D2W-1:0]     dx_ext, dy_ext;
  logic signed [D2W-1:0]     dist2;
  logic                      inside_disc;
  logic                      span_ok;

  // Row advance shared by the empty-span and end-of-span paths.
  logic signed [SW-1:0]      row_adv, lo_adv, hi_adv;
  logic [COORD_W-1:0]        rows_left_adv;
  logic signed [DW-1:0]      dy_adv;
  logic signed [D2W-1:0]     dy2_adv;

  assign x_s      = $signed({{(SW-COORD_W){1'b0}}, in_x_pos});
  assign y_s      = $signed({{(SW-COORD_W){1'b0}}, in_y_pos});
  assign w_s      = $signed({{(SW-COORD_W){1'b0}}, in_box_width});
  assign half_h_s = $signed({{(SW-COORD_W+1){1'b0}}, in_box_height[COORD_W-1:1]});
  assign r_s      = $signed({{(SW-RAD_W){1'b0}}, in_circle_radius});
  assign rad_sq   = SQW'(in_circle_radius) * SQW'(in_circle_radius);

  assign c0 = (lo_r < 0) ? '0 : lo_r;
  assign c1 = (hi_r > MAX_COL) ? MAX_COL : hi_r;

  assign neg_rad = -$signed({1'b0, radius_r});
  assign dx_ext  = {{(D2W-DW){dx_r[DW-1]}}, dx_r};
  assign dy_ext  = {{(D2W-DW){dy_r[DW-1]}}, dy_r};
  assign dist2   = dx2_r + dy2_r;
  assign inside_disc = dist2 < $signed({2'b00, lim_r});

  assign row_adv       = row_r + SW'(1);
  assign rows_left_adv = rows_left_r - COORD_W'(1);
  assign lo_adv        = (func_r == FUNC_TRI) ? lo_r - SW'(1) : lo_r;
  assign hi_adv        = (func_r == FUNC_TRI) ? hi_r + SW'(1) : hi_r;
  assign dy_adv        = dy_r + DW'(1);
  assign dy2_adv       = dy2_r + (dy_ext <<< 1) + D2W'(1);

  // Reads wait for a free output register; draws never do.
  assign in_ready = (state_r == ST_IDLE) &&
                    ((func_t'(in_func) != FUNC_READ) || !out_valid_r || out_ready);
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r            <= func_nxt;
    level_r           <= level_nxt;
    row_r             <= row_nxt;
    col_r             <= col_nxt;
    lo_r              <= lo_nxt;
    hi_r              <= hi_nxt;
    span_hi_r         <= span_hi_nxt;
    rows_left_r       <= rows_left_nxt;
    radius_r          <= radius_nxt;
    lim_r             <= lim_nxt;
    dx_r              <= dx_nxt;
    dy_r              <= dy_nxt;
    dx2_r             <= dx2_nxt;
    dy2_r             <= dy2_nxt;
    rd_in_r           <= rd_in_nxt;
    out_pixel_value_r <= out_pixel_value_nxt;
  end

  always_comb begin
    state_nxt           = state_r;
    func_nxt            = func_r;
    clr_nxt             = clr_r;
    level_nxt           = level_r;
    row_nxt             = row_r;
    col_nxt             = col_r;
    lo_nxt              = lo_r;
    hi_nxt              = hi_r;
    span_hi_nxt         = span_hi_r;
    rows_left_nxt       = rows_left_r;
    radius_nxt          = radius_r;
    lim_nxt             = lim_r;
    dx_nxt              = dx_r;
    dy_nxt              = dy_r;
    dx2_nxt             = dx2_r;
    dy2_nxt             = dy2_r;
    rd_in_nxt           = rd_in_r;
    out_valid_nxt       = out_valid_r && !out_ready;
    out_pixel_value_nxt = out_pixel_value_r;
    mem_en              = 1'b0;
    mem_we              = 1'b0;
    mem_addr            = {row_r[CW-1:0], col_r[CW-1:0]};
    mem_wdata           = level_r;

    unique case (state_r)
      ST_CLEAR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = clr_r;
        mem_wdata = WHITE_LEVEL;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_xfer) begin
          func_nxt   = func_t'(in_func);
          level_nxt  = in_gray_level;
          row_nxt    = y_s;
          radius_nxt = in_circle_radius;
          lim_nxt    = rad_sq;
          dy_nxt     = -$signed({1'b0, in_circle_radius});
          dy2_nxt    = $signed({2'b00, rad_sq});
          unique case (func_t'(in_func))
            FUNC_RECT: begin
              lo_nxt        = x_s;
              hi_nxt        = x_s + w_s - SW'(1);
              rows_left_nxt = (in_box_width == '0) ? '0 : in_box_height;
              state_nxt     = ST_ROW;
            end
            FUNC_TRI: begin
              lo_nxt        = x_s + half_h_s;
              hi_nxt        = x_s + half_h_s;
              rows_left_nxt = in_box_height;
              state_nxt     = ST_ROW;
            end
            FUNC_CIRCLE: begin
              lo_nxt        = x_s;
              hi_nxt        = x_s + (r_s <<< 1) - SW'(1);
              rows_left_nxt = {in_circle_radius, 1'b0};
              state_nxt     = ST_ROW;
            end
            FUNC_READ: begin
              mem_en    = 1'b1;
              mem_addr  = {y_s[CW-1:0], x_s[CW-1:0]};
              rd_in_nxt = (x_s < CANVAS_S) && (y_s < CANVAS_S);
              state_nxt = ST_READ;
            end
          endcase
        end
      end

      ST_ROW: begin
        if (rows_left_r == '0 || row_r >= CANVAS_S) begin
          state_nxt = ST_IDLE;
        end else if (c0 <= c1) begin
          col_nxt     = c0;
          span_hi_nxt = c1;
          dx_nxt      = neg_rad;
          dx2_nxt     = $signed({2'b00, lim_r});
          state_nxt   = ST_SPAN;
        end else begin
          // skip a row whose span lies wholly off the canvas
          row_nxt       = row_adv;
          rows_left_nxt = rows_left_adv;
          lo_nxt        = lo_adv;
          hi_nxt        = hi_adv;
          dy_nxt        = dy_adv;
          dy2_nxt       = dy2_adv;
        end
      end

      ST_SPAN: begin
        mem_en  = (func_r != FUNC_CIRCLE) || inside_disc;
        mem_we  = mem_en;
        col_nxt = col_r + SW'(1);
        dx_nxt  = dx_r + DW'(1);
        dx2_nxt = dx2_r + (dx_ext <<< 1) + D2W'(1);
        if (col_r == span_hi_r) begin
          row_nxt       = row_adv;
          rows_left_nxt = rows_left_adv;
          lo_nxt        = lo_adv;
          hi_nxt        = hi_adv;
          dy_nxt        = dy_adv;
          dy2_nxt       = dy2_adv;
          state_nxt     = ST_ROW;
        end
      end

      ST_READ: begin
        // all earlier writes have landed, so the read data is current
        out_valid_nxt       = 1'b1;
        out_pixel_value_nxt = rd_in_r ? mem_rdata : '0;
        state_nxt           = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  frs_ram #(
    .WIDTH(LEVEL_W),
    .DEPTH(DEPTH)
  ) u_frame_store (
    .clk  (clk),
    .en   (mem_en),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  assign out_valid       = out_valid_r;
  assign out_pixel_value = out_pixel_value_r;

  assign span_ok = (col_r >= 0) && (col_r <= span_hi_r) && (span_hi_r < CANVAS_S) &&
                   (row_r >= 0) && (row_r < CANVAS_S);

  `FRS_ASSERT(a_no_cmd_during_clear, (state_r == ST_CLEAR) |-> !in_ready, "command in clear")
  `FRS_ASSERT(a_out_free_at_read, (state_r == ST_READ) |-> !out_valid_r, "result overwritten")
  `FRS_ASSERT(a_read_follows_xfer, (state_r == ST_READ) |-> $past(in_xfer), "stray read state")
  `FRS_ASSERT(a_span_on_canvas, (state_r == ST_SPAN) |-> span_ok, "span pixel off the canvas")
  `FRS_NEVER(a_write_source, mem_we && state_r != ST_CLEAR && state_r != ST_SPAN, "stray write")

endmodule

// ----- tb/frs_checker.sv -----
// Scoreboard for the filled shape rasterizer: keeps a shadow frame store,
// updates it from observed command transfers and checks every pixel read.
// Depends on frs_pkg.
module frs_checker
  import frs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [COORD_W-1:0] in_x_pos,
  input  logic [COORD_W-1:0] in_y_pos,
  input  logic [COORD_W-1:0] in_box_width,
  input  logic [COORD_W-1:0] in_box_height,
  input  logic [RAD_W-1:0]   in_circle_radius,
  input  logic [LEVEL_W-1:0] in_gray_level,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [LEVEL_W-1:0] out_pixel_value,
  output int                 fail_count,
  output int                 reads_pending
);

  localparam int SIDE  = CANVAS_SIZE_DEF;
  localparam int IDX_W = $clog2(SIDE * SIDE);

  typedef struct {
    int                 col;
    int                 row;
    logic [LEVEL_W-1:0] level;
  } pixel_read_t;

  logic [LEVEL_W-1:0] shadow [SIDE*SIDE];
  pixel_read_t        reads_due [$];
  pixel_read_t        head;
  int                 errors;

  function automatic void plot(int row, int col, logic [LEVEL_W-1:0] level);
    if (row < 0 || col < 0 || row >= SIDE || col >= SIDE) return;
    shadow[IDX_W'(row*SIDE + col)] = level;
  endfunction

  function automatic void fill_run(int row, int c0, int c1, logic [LEVEL_W-1:0] level);
    int lo, hi;
    if (row < 0 || row >= SIDE) return;
    lo = (c0 < 0) ? 0 : c0;
    hi = (c1 > SIDE - 1) ? SIDE - 1 : c1;
    for (int c = lo; c <= hi; c++) plot(row, c, level);
  endfunction

  // Paint a shape into the shadow store, or queue the pixel a read returns.
  function automatic void track_command(func_t op, int x, int y, int w, int h, int rad,
                                        logic [LEVEL_W-1:0] level);
    int          half, cx, cy, lim, dx, dy;
    pixel_read_t pr;
    case (op)
      FUNC_RECT: begin
        if (w > 0)
          for (int r = y; r < y + h && r < SIDE; r++) fill_run(r, x, x + w - 1, level);
      end
      FUNC_TRI: begin
        half = h / 2;
        for (int k = 0; k < h && y + k < SIDE; k++)
          fill_run(y + k, x + half - k, x + half + k, level);
      end
      FUNC_CIRCLE: begin
        cx  = x + rad;
        cy  = y + rad;
        lim = rad * rad;
        for (int r = y; r < y + 2*rad && r < SIDE; r++) begin
          dy = r - cy;
          for (int c = x; c < x + 2*rad && c < SIDE; c++) begin
            dx = c - cx;
            if (dx*dx + dy*dy < lim) plot(r, c, level);
          end
        end
      end
      default: begin
        pr.col   = x;
        pr.row   = y;
        pr.level = (x < SIDE && y < SIDE) ? shadow[IDX_W'(y*SIDE + x)] : '0;
        reads_due.push_back(pr);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (shadow[i]) shadow[i] = WHITE_LEVEL;
      reads_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (reads_due.size() == 0) begin
          errors++;
          $display("%0t: pixel value %0d returned with no read outstanding",
                   $time, out_pixel_value);
        end else begin
          head = reads_due.pop_front();
          if (out_pixel_value !== head.level) begin
            errors++;
            $display("%0t: pixel (%0d,%0d) expected %0d, got %0d",
                     $time, head.col, head.row, head.level, out_pixel_value);
          end
        end
      end
      if (in_valid && in_ready)
        track_command(func_t'(in_func), int'(in_x_pos), int'(in_y_pos), int'(in_box_width),
                      int'(in_box_height), int'(in_circle_radius), in_gray_level);
    end
    fail_count    <= errors;
    reads_pending <= reads_due.size();
  end

endmodule

// ----- tb/filled_shape_rasterizer_tb.sv -----
// Testbench top for filled_shape_rasterizer: drives directed and random draw
// and read commands with random idling on both channels; frs_checker scores.
// Depends on frs_pkg, filled_shape_rasterizer and frs_checker.
module filled_shape_rasterizer_tb;
  import frs_pkg::*;

  typedef struct {
    func_t              op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic [RAD_W-1:0]   rad;
    logic [LEVEL_W-1:0] level;
  } shape_cmd_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [FUNC_W-1:0]  in_func;
  logic [COORD_W-1:0] in_x_pos;
  logic [COORD_W-1:0] in_y_pos;
  logic [COORD_W-1:0] in_box_width;
  logic [COORD_W-1:0] in_box_height;
  logic [RAD_W-1:0]   in_circle_radius;
  logic [LEVEL_W-1:0] in_gray_level;
  logic               out_valid;
  logic               out_ready;
  logic [LEVEL_W-1:0] out_pixel_value;
  int                 fail_count;
  int                 reads_pending;

  shape_cmd_t opening [$];
  shape_cmd_t next_cmd;
  bit         burst;
  int         box_col, box_row, box_ext;
  int         rx_hold, rx_pick;

  always #10 clk = ~clk;

  filled_shape_rasterizer dut (.*);

  frs_checker u_checker (.*);

  function automatic shape_cmd_t cmd_of(func_t op, int x, int y, int w, int h, int rad,
                                        int level);
    shape_cmd_t c;
    c.op    = op;
    c.x     = COORD_W'(x);
    c.y     = COORD_W'(y);
    c.w     = COORD_W'(w);
    c.h     = COORD_W'(h);
    c.rad   = RAD_W'(rad);
    c.level = LEVEL_W'(level);
    return c;
  endfunction

  function automatic shape_cmd_t random_shape();
    shape_cmd_t c;
    int         pick, cls;
    pick    = $urandom_range(0, 99);
    cls     = $urandom_range(0, 99);
    c.x     = COORD_W'($urandom);
    c.y     = COORD_W'($urandom);
    c.w     = COORD_W'($urandom);
    c.h     = COORD_W'($urandom);
    c.rad   = RAD_W'($urandom);
    c.level = LEVEL_W'($urandom);
    if (pick < 35) begin
      c.op = FUNC_READ;
      // aim most reads at the last shape so its coverage gets checked
      if ($urandom_range(0, 3) != 0) begin
        c.x = COORD_W'(box_col + int'($urandom_range(0, box_ext)));
        c.y = COORD_W'(box_row + int'($urandom_range(0, box_ext)));
      end
    end else begin
      c.op = (pick < 60) ? FUNC_RECT : (pick < 80) ? FUNC_TRI : FUNC_CIRCLE;
      if (cls < 70) begin
        c.w   = COORD_W'($urandom_range(0, 12));
        c.h   = COORD_W'($urandom_range(0, 12));
        c.rad = RAD_W'($urandom_range(0, 6));
      end else if (cls < 98) begin
        c.w   = COORD_W'($urandom_range(0, 24));
        c.h   = COORD_W'($urandom_range(0, 24));
        c.rad = RAD_W'($urandom_range(0, 12));
      end else begin
        // keep full sizes, start near the bottom edge so few rows are walked
        c.y = COORD_W'($urandom_range(496, 511));
      end
    end
    return c;
  endfunction

  task automatic issue(shape_cmd_t c);
    in_valid         <= 1'b1;
    in_func          <= c.op;
    in_x_pos         <= c.x;
    in_y_pos         <= c.y;
    in_box_width     <= c.w;
    in_box_height    <= c.h;
    in_circle_radius <= c.rad;
    in_gray_level    <= c.level;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_after();
    int n, pick;
    pick = $urandom_range(0, 99);
    if (burst || pick < 50) n = 0;
    else if (pick < 88) n = $urandom_range(1, 3);
    else if (pick < 97) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 120);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold the sender until every outstanding read has been returned.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reads_pending != 0) @(posedge clk);
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
      end else begin
        rx_pick = $urandom_range(0, 99);
        if (rx_pick < 55) begin
          out_ready <= 1'b1;
          rx_hold = $urandom_range(1, 20);
        end else if (rx_pick < 65) begin
          out_ready <= 1'b1;
          rx_hold = $urandom_range(100, 400);
        end else if (rx_pick < 93) begin
          out_ready <= 1'b0;
          rx_hold = $urandom_range(1, 4);
        end else begin
          out_ready <= 1'b0;
          rx_hold = $urandom_range(30, 150);
        end
      end
    end
  end

  initial begin
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_func          <= '0;
    in_x_pos         <= '0;
    in_y_pos         <= '0;
    in_box_width     <= '0;
    in_box_height    <= '0;
    in_circle_radius <= '0;
    in_gray_level    <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    opening.push_back(cmd_of(FUNC_READ,     0,   0,   0,   0,   0,    0));
    opening.push_back(cmd_of(FUNC_READ,   511, 511,   0,   0,   0,    0));
    opening.push_back(cmd_of(FUNC_RECT,     0,   0,   1,   1,   0,    0));
    opening.push_back(cmd_of(FUNC_READ,     0,   0,   0,   0,   0,    0));
    // zero width, zero height and zero radius draw nothing
    opening.push_back(cmd_of(FUNC_RECT,    10,  10,   0,   5,   0,    7));
    opening.push_back(cmd_of(FUNC_READ,    10,  10,   0,   0,   0,    0));
    opening.push_back(cmd_of(FUNC_RECT,    20,  20,   5,   0,   0,    9));
    opening.push_back(cmd_of(FUNC_READ,    20,  20,   0,   0,   0,    0));
    opening.push_back(cmd_of(FUNC_CIRCLE,  30,  30,   0,   0,   0,   11));
    opening.push_back(cmd_of(FUNC_READ,    30,  30,   0,   0,   0,    0));
    // shapes clipped at the right and bottom edges
    opening.push_back(cmd_of(FUNC_RECT,   505, 509, 511, 511,   0, 'h5A));
    opening.push_back(cmd_of(FUNC_READ,   511, 511,   0,   0,   0,    0));
    opening.push_back(cmd_of(FUNC_RECT,     0, 508, 511,   4,   0, 'hA5));
    opening.push_back(cmd_of(FUNC_RECT,   511,   0,   1, 511,   0, 'h3C));
    opening.push_back(cmd_of(FUNC_READ,   511, 200,   0,   0,   0,    0));
    opening.push_back(cmd_of(FUNC_TRI,      0, 505,   0, 511,   0, 'h81));
    opening.push_back(cmd_of(FUNC_READ,   255, 505,   0,   0,   0,    0));
    // triangle spans that start left of column zero
    opening.push_back(cmd_of(FUNC_TRI,      0,  50,   0,  20,   0, 'h42));
    opening.push_back(cmd_of(FUNC_READ,     0,  69,   0,   0,   0,    0));
    opening.push_back(cmd_of(FUNC_TRI,    100, 100,   0,   2,   0,    1));
    opening.push_back(cmd_of(FUNC_READ,   101, 100,   0,   0,   0,    0));
    opening.push_back(cmd_of(FUNC_CIRCLE,   0, 500,   0,   0, 255, 'hC3));
    opening.push_back(cmd_of(FUNC_READ,   255, 511,   0,   0,   0,    0));
    opening.push_back(cmd_of(FUNC_CIRCLE, 200, 200,   0,   0,   1, 'h66));
    opening.push_back(cmd_of(FUNC_READ,   201, 201,   0,   0,   0,    0));
    opening.push_back(cmd_of(FUNC_CIRCLE, 504, 504,   0,   0,   8, 'h77));
    opening.push_back(cmd_of(FUNC_READ,   510, 510,   0,   0,   0,    0));
    opening.push_back(cmd_of(FUNC_RECT,     0,   0,   1,   1,   0, 'hFF));
    opening.push_back(cmd_of(FUNC_READ,     0,   0,   0,   0,   0,    0));

    burst = 1'b0;
    foreach (opening[i]) begin
      issue(opening[i]);
      idle_after();
    end

    for (int i = 0; i < 580; i++) begin
      if (i % 60 == 0) burst = ($urandom_range(0, 3) == 0);
      if (i % 200 == 100) drain();
      next_cmd = random_shape();
      if (next_cmd.op != FUNC_READ) begin
        box_col = int'(next_cmd.x);
        box_row = int'(next_cmd.y);
        if (next_cmd.op == FUNC_CIRCLE) box_ext = 2 * int'(next_cmd.rad);
        else box_ext = (next_cmd.w > next_cmd.h) ? int'(next_cmd.w) : int'(next_cmd.h);
      end
      issue(next_cmd);
      idle_after();
    end

    drain();
    // let the last draw finish before closing the run
    while (!in_ready) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && reads_pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/frs_pkg.sv
sv/frs_ram.sv
sv/filled_shape_rasterizer.sv
tb/frs_checker.sv
tb/filled_shape_rasterizer_tb.sv
